// ===== hw/rtl/slrp_pkg.sv =====
// Shared types, character codes and the byte classifier of the seed line
// record parser. No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package slrp_pkg;

   // Width of every count field on the result channel but line_length, which is one bit.
   localparam int FIELD_WIDTH = 32;
   // Default width of the running position, line and length counters.
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Depth of the queue between the classifier and the scanner.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] NUL_CHAR   = 8'h00;
   localparam logic [7:0] TAB_CHAR   = 8'h09;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] HASH_CHAR  = 8'h23;
   localparam logic [7:0] COLON_CHAR = 8'h3A;

   // Tag that follows the hash of an ancestor line: "name:" and a tab.
   localparam int TAG_LENGTH = 6;
   localparam int TAG_INDEX_WIDTH = $clog2(TAG_LENGTH);
   localparam logic [7:0] TAG_TEXT [TAG_LENGTH] =
      '{8'h6E, 8'h61, 8'h6D, 8'h65, COLON_CHAR, TAB_CHAR};

   typedef enum logic [2:0] {
      MODE_LINE_START,
      MODE_TAG,
      MODE_NAME_FIRST,
      MODE_NAME_VALUE,
      MODE_REST,
      MODE_FATHER_FIRST,
      MODE_FATHER_WORD,
      MODE_WORD
   } scan_mode_type;

   // A byte once classified: everything the scanner needs to know of it.
   typedef struct packed {
      logic [TAG_LENGTH-1:0] tag_hit;
      logic                  is_lf;
      logic                  is_cr;
      logic                  is_nul;
      logic                  is_tab;
      logic                  is_space;
      logic                  is_hash;
      logic                  final_byte;
   } byte_class_type;

   // One result word.
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] ancestor_offset;
      logic [FIELD_WIDTH-1:0] ancestor_length;
      logic [FIELD_WIDTH-1:0] father_offset;
      logic [FIELD_WIDTH-1:0] father_length;
      logic [FIELD_WIDTH-1:0] line_number;
      logic [FIELD_WIDTH-1:0] word_offset;
      logic [FIELD_WIDTH-1:0] word_length;
   } record_type;

   function automatic byte_class_type classify(input logic [7:0] data, input logic last);
      byte_class_type c;
      for (int i = 0; i < TAG_LENGTH; i++) begin
         c.tag_hit[i] = (data == TAG_TEXT[i]);
      end
      c.is_lf      = (data == LF_CHAR);
      c.is_cr      = (data == CR_CHAR);
      c.is_nul     = (data == NUL_CHAR);
      c.is_tab     = (data == TAB_CHAR);
      c.is_space   = (data == SPACE_CHAR);
      c.is_hash    = (data == HASH_CHAR);
      c.final_byte = last;
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slrp_if.sv =====
// Channel interfaces of the seed line record parser: the byte channel and
// the record channel. Depends on slrp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface slrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface slrp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [slrp_pkg::FIELD_WIDTH-1:0] ancestor_offset;
   logic [slrp_pkg::FIELD_WIDTH-1:0] ancestor_length;
   logic [slrp_pkg::FIELD_WIDTH-1:0] father_offset;
   logic [slrp_pkg::FIELD_WIDTH-1:0] father_length;
   logic [slrp_pkg::FIELD_WIDTH-1:0] line_number;
   logic                             line_length;
   logic [slrp_pkg::FIELD_WIDTH-1:0] word_offset;
   logic [slrp_pkg::FIELD_WIDTH-1:0] word_length;

   modport source (output valid, output ancestor_offset, output ancestor_length,
                   output father_offset, output father_length, output line_number,
                   output line_length, output word_offset, output word_length,
                   input ready);
   modport sink   (input valid, input ancestor_offset, input ancestor_length,
                   input father_offset, input father_length, input line_number,
                   input line_length, input word_offset, input word_length,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slrp_front.sv =====
// Front end: takes words from the byte channel, classifies each byte and
// pushes the class into the queue. Depends on slrp_pkg and slrp_if.
`timescale 1ns / 1ps
`default_nettype none

module slrp_front (
   slrp_req_if.sink                 req_ch,
   input  wire logic                q_full,
   output      logic                q_push,
   output      slrp_pkg::byte_class_type q_push_data
);

   // The channel only waits on queue space, never on the scanner.
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;
   assign q_push_data  = slrp_pkg::classify(req_ch.data_byte, req_ch.final_byte);

endmodule

`default_nettype wire

// ===== hw/rtl/slrp_queue.sv =====
// Short first-in first-out queue of classified bytes between the front end
// and the scanner. Depends on slrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slrp_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire slrp_pkg::byte_class_type push_data,
   output      logic                     full,
   input  wire logic                     pop,
   output      logic                     valid,
   output      slrp_pkg::byte_class_type head
);

   localparam int DEPTH = slrp_pkg::QUEUE_DEPTH;
   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   slrp_pkg::byte_class_type entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/slrp_back.sv =====
// Back end: the line scanner with its counters and the output register that
// holds a record until the record channel takes it. Depends on slrp_pkg, slrp_if.
`timescale 1ns / 1ps
`default_nettype none

module slrp_back #(
   parameter int COUNT_WIDTH = slrp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire slrp_pkg::byte_class_type q_head,
   output      logic                     q_pop,
   slrp_rsp_if.source                    rsp_ch
);

   localparam int FW = slrp_pkg::FIELD_WIDTH;
   localparam int TW = slrp_pkg::TAG_INDEX_WIDTH;

   slrp_pkg::scan_mode_type mode_ff, mode_in;
   logic [TW-1:0]          tag_idx_ff, tag_idx_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] anc_off_ff, anc_off_in;
   logic [COUNT_WIDTH-1:0] anc_len_ff, anc_len_in;
   logic [COUNT_WIDTH-1:0] fat_off_ff, fat_off_in;
   logic [COUNT_WIDTH-1:0] fat_len_ff, fat_len_in;
   logic [COUNT_WIDTH-1:0] word_off_ff, word_off_in;
   logic [COUNT_WIDTH-1:0] word_len_ff, word_len_in;
   logic                   pending_ff, pending_in;
   logic                   after_cr_ff, after_cr_in;
   logic                   phase_ff, phase_in;
   logic                   out_valid_ff, out_valid_in;
   slrp_pkg::record_type   rec_ff;

   slrp_pkg::byte_class_type cls;
   logic is_stop, emit, dispatch, skip;
   logic out_free, active, clear, go_phase;

   // Scanner step for one byte class.
   always_comb begin
      cls = phase_ff ? slrp_pkg::classify(slrp_pkg::LF_CHAR, 1'b0) : q_head;
      is_stop = cls.is_nul || cls.is_lf || cls.is_cr;

      mode_in     = mode_ff;
      tag_idx_in  = tag_idx_ff;
      pos_in      = pos_ff + COUNT_WIDTH'(1);
      line_in     = line_ff;
      anc_off_in  = anc_off_ff;
      anc_len_in  = anc_len_ff;
      fat_off_in  = fat_off_ff;
      fat_len_in  = fat_len_ff;
      word_off_in = word_off_ff;
      word_len_in = word_len_ff;
      pending_in  = pending_ff;
      after_cr_in = after_cr_ff;
      emit        = 1'b0;
      dispatch    = 1'b0;
      skip        = 1'b0;

      // An LF straight after a CR belongs to the same line end.
      if (after_cr_ff) begin
         after_cr_in = 1'b0;
         skip        = cls.is_lf;
      end

      if (!skip) begin
         unique case (mode_ff)
            slrp_pkg::MODE_TAG: begin
               if ((tag_idx_ff < TW'(slrp_pkg::TAG_LENGTH)) && cls.tag_hit[tag_idx_ff]) begin
                  if (tag_idx_ff == TW'(slrp_pkg::TAG_LENGTH - 1)) begin
                     tag_idx_in = '0;
                     mode_in    = slrp_pkg::MODE_NAME_FIRST;
                  end else begin
                     tag_idx_in = tag_idx_ff + TW'(1);
                  end
               end else begin
                  tag_idx_in = '0;
                  mode_in    = slrp_pkg::MODE_REST;
                  dispatch   = is_stop;
               end
            end
            slrp_pkg::MODE_NAME_FIRST: begin
               anc_off_in = pos_ff;
               if (is_stop) begin
                  anc_len_in = '0;
                  dispatch   = 1'b1;
               end else begin
                  anc_len_in = COUNT_WIDTH'(1);
                  mode_in    = slrp_pkg::MODE_NAME_VALUE;
               end
            end
            slrp_pkg::MODE_NAME_VALUE: begin
               if (is_stop) begin
                  dispatch = 1'b1;
               end else begin
                  anc_len_in = anc_len_ff + COUNT_WIDTH'(1);
               end
            end
            slrp_pkg::MODE_REST: begin
               dispatch = is_stop;
            end
            slrp_pkg::MODE_FATHER_FIRST: begin
               // The byte after the tab is always the first father byte.
               fat_off_in = pos_ff;
               fat_len_in = COUNT_WIDTH'(1);
               pending_in = 1'b1;
               mode_in    = slrp_pkg::MODE_FATHER_WORD;
            end
            slrp_pkg::MODE_FATHER_WORD, slrp_pkg::MODE_WORD: begin
               if (is_stop) begin
                  dispatch = 1'b1;
               end else if (cls.is_tab || cls.is_space) begin
                  mode_in = slrp_pkg::MODE_REST;
               end else if (mode_ff == slrp_pkg::MODE_WORD) begin
                  word_len_in = word_len_ff + COUNT_WIDTH'(1);
               end else begin
                  fat_len_in = fat_len_ff + COUNT_WIDTH'(1);
               end
            end
            default: begin
               dispatch = 1'b1;
            end
         endcase

         // Treat the byte as the first of a line.
         if (dispatch) begin
            if (cls.is_lf || cls.is_cr) begin
               line_in     = line_ff + COUNT_WIDTH'(1);
               after_cr_in = cls.is_cr;
               mode_in     = slrp_pkg::MODE_LINE_START;
               emit        = pending_ff;
               pending_in  = 1'b0;
            end else if (cls.is_hash) begin
               mode_in    = slrp_pkg::MODE_TAG;
               tag_idx_in = '0;
            end else if (cls.is_tab) begin
               mode_in = slrp_pkg::MODE_FATHER_FIRST;
            end else begin
               word_off_in = pos_ff;
               word_len_in = COUNT_WIDTH'(1);
               pending_in  = 1'b1;
               mode_in     = slrp_pkg::MODE_WORD;
            end
         end
      end
   end

   // A final byte takes a second step for the implied LF unless it already
   // gave a record; either way the state is cleared afterwards.
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign active   = q_valid && out_free;
   assign clear    = active && (phase_ff || (q_head.final_byte && emit));
   assign go_phase = active && !phase_ff && q_head.final_byte && !emit;
   assign q_pop    = active && !go_phase;
   assign phase_in = go_phase;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (active && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         mode_ff     <= slrp_pkg::MODE_LINE_START;
         tag_idx_ff  <= '0;
         pos_ff      <= '0;
         line_ff     <= '0;
         anc_off_ff  <= '0;
         anc_len_ff  <= '0;
         fat_off_ff  <= '0;
         fat_len_ff  <= '0;
         word_off_ff <= '0;
         word_len_ff <= '0;
         pending_ff  <= 1'b0;
         after_cr_ff <= 1'b0;
      end else if (active) begin
         mode_ff     <= mode_in;
         tag_idx_ff  <= tag_idx_in;
         pos_ff      <= pos_in;
         line_ff     <= line_in;
         anc_off_ff  <= anc_off_in;
         anc_len_ff  <= anc_len_in;
         fat_off_ff  <= fat_off_in;
         fat_len_ff  <= fat_len_in;
         word_off_ff <= word_off_in;
         word_len_ff <= word_len_in;
         pending_ff  <= pending_in;
         after_cr_ff <= after_cr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (active) begin
            phase_ff <= phase_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (active && emit) begin
         rec_ff.ancestor_offset <= FW'(anc_off_in);
         rec_ff.ancestor_length <= FW'(anc_len_in);
         rec_ff.father_offset   <= FW'(fat_off_in);
         rec_ff.father_length   <= FW'(fat_len_in);
         rec_ff.line_number     <= FW'(line_in);
         rec_ff.word_offset     <= FW'(word_off_in);
         rec_ff.word_length     <= FW'(word_len_in);
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.ancestor_offset = rec_ff.ancestor_offset;
   assign rsp_ch.ancestor_length = rec_ff.ancestor_length;
   assign rsp_ch.father_offset   = rec_ff.father_offset;
   assign rsp_ch.father_length   = rec_ff.father_length;
   assign rsp_ch.line_number     = rec_ff.line_number;
   assign rsp_ch.line_length     = 1'b0;
   assign rsp_ch.word_offset     = rec_ff.word_offset;
   assign rsp_ch.word_length     = rec_ff.word_length;

endmodule

`default_nettype wire

// ===== hw/rtl/seed_line_record_parser.sv =====
// Seed line record parser, top level: front end, queue and scanner.
// Depends on slrp_pkg, slrp_if, slrp_front, slrp_queue and slrp_back.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes a text file one byte per word on the req_ch channel and
// gives one record word on rsp_ch for each line that set a father or a line
// word, when that line ends (LF, CR, or CR followed by LF, which counts once).
// Throughput is one byte per clock cycle while the record channel keeps up. A
// byte marked final_byte costs the scanner a second step for the implied
// trailing LF unless that byte itself closes a record; after it all counters
// and scanner state return to their reset values, ready for the next file.
// The scanner step is the one loop: it handles one classified byte per cycle
// while the output register is free, so the sustained rate is set by it. An
// accepted byte reaches the record it closes through the classifier queue,
// then through the scanner into the output register. The front end accepts
// bytes as long as the two-word queue has room, so a stalled record channel
// backs up the byte channel only after the queue has filled. Positions, lengths
// and the line count are COUNT_WIDTH bits wide and wrap; they are zero-extended
// to 32 bits on the record channel, and line_length is always zero.
module seed_line_record_parser #(
   parameter int COUNT_WIDTH = slrp_pkg::COUNT_WIDTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   slrp_req_if.sink   req_ch,
   slrp_rsp_if.source rsp_ch
);

   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_valid;
   slrp_pkg::byte_class_type q_push_data;
   slrp_pkg::byte_class_type q_head;

   // Classifies each byte as it arrives.
   slrp_front u_front (
      .req_ch      (req_ch),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // Lets the front end keep accepting while the scanner waits on the output.
   slrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // Runs the line scanner and holds the outgoing record.
   slrp_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // The scanner never takes a word from an empty queue.
   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("scanner popped an empty queue");

   // After reset the queue is empty and the byte channel is open.
   a_ready_after_reset : assert property (@(posedge clock)
      reset |=> req_ch.ready)
      else $error("byte channel not ready after reset");

   // An accepted byte is waiting for the scanner in the next cycle.
   a_accept_fills_queue : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> q_valid)
      else $error("accepted byte missing from the queue");

endmodule

`default_nettype wire
